// File: rtl/ots_pkg.sv
`timescale 1ns / 1ps

package ots_pkg;

    // Font ROM shape: one row of glyph bytes per printable code
    localparam int ROM_GLYPHS   = 96;
    localparam int ROM_STRIDE   = 12;
    localparam int ROW_W        = $clog2(ROM_STRIDE);
    localparam int GLYPH_IDX_W  = $clog2(ROM_GLYPHS);

    localparam int GLYPH_COUNT         = 96;
    localparam int GLYPH_BYTES_DEFAULT = 12;

    // Two 3-byte command transfers precede the glyph data
    localparam int CMD_BYTES = 6;

    localparam int COL_W    = 7;
    localparam int COL_STEP = 7;
    localparam int COL_SPAN = 5;

    localparam logic [7:0] CMD_COLUMN_ADDR = 8'h21;
    localparam logic [7:0] CMD_PAGE_ADDR   = 8'h22;

    localparam logic [7:0] CHAR_LF         = 8'h0A;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_FIRST      = 8'h20;
    localparam logic [7:0] CHAR_LAST_PRINT = 8'h7F;

    localparam logic ACTION_RENDER  = 1'b0;
    localparam logic ACTION_RESTART = 1'b1;

    typedef logic [0:ROM_STRIDE-1][7:0] glyph_row_t;

    // One glyph request handed from the front to the back
    typedef struct packed {
        logic [GLYPH_IDX_W-1:0] glyph;
        logic                   bad;
        logic [COL_W-1:0]       col;
        logic                   lower;
    } ots_job_t;

    localparam glyph_row_t GLYPH_ROM [ROM_GLYPHS] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'hfc,8'h00,8'h00,8'h00,8'h00,8'h00,8'h0d,8'h00,8'h00},
        '{8'h00,8'h00,8'h1e,8'h00,8'h1e,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h20,8'hfc,8'h20,8'hfc,8'h20,8'h00,8'h01,8'h0f,8'h01,8'h0f,8'h01},
        '{8'h30,8'h48,8'h88,8'hfc,8'h88,8'h30,8'h06,8'h08,8'h08,8'h1f,8'h08,8'h07},
        '{8'h18,8'h24,8'ha4,8'h78,8'h10,8'h0c,8'h0c,8'h02,8'h07,8'h09,8'h09,8'h06},
        '{8'h00,8'hb8,8'hc4,8'h44,8'h38,8'h80,8'h07,8'h08,8'h08,8'h05,8'h06,8'h09},
        '{8'h00,8'h00,8'h00,8'h1e,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'he0,8'h18,8'h04,8'h02,8'h00,8'h00,8'h03,8'h0c,8'h10,8'h20},
        '{8'h00,8'h02,8'h04,8'h18,8'he0,8'h00,8'h00,8'h20,8'h10,8'h0c,8'h03,8'h00},
        '{8'h00,8'h20,8'h40,8'hf0,8'h40,8'h20,8'h00,8'h02,8'h01,8'h07,8'h01,8'h02},
        '{8'h00,8'h80,8'h80,8'hf0,8'h80,8'h80,8'h00,8'h00,8'h00,8'h07,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h24,8'h1c,8'h00,8'h00},
        '{8'h00,8'h80,8'h80,8'h80,8'h80,8'h80,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h08,8'h1c,8'h08,8'h00},
        '{8'h00,8'h00,8'h00,8'he0,8'h18,8'h06,8'h30,8'h0c,8'h03,8'h00,8'h00,8'h00},
        '{8'hf0,8'h08,8'h04,8'h04,8'h08,8'hf0,8'h03,8'h04,8'h08,8'h08,8'h04,8'h03},
        '{8'h00,8'h10,8'h08,8'hfc,8'h00,8'h00,8'h00,8'h08,8'h08,8'h0f,8'h08,8'h08},
        '{8'h18,8'h04,8'h04,8'h04,8'hc4,8'h38,8'h08,8'h0c,8'h0a,8'h09,8'h08,8'h08},
        '{8'h04,8'h04,8'h44,8'h64,8'h54,8'h8c,8'h06,8'h08,8'h08,8'h08,8'h08,8'h07},
        '{8'h00,8'hc0,8'h30,8'h08,8'hfc,8'h00,8'h03,8'h02,8'h02,8'h02,8'h0f,8'h02},
        '{8'h7c,8'h24,8'h24,8'h24,8'h24,8'hc4,8'h06,8'h08,8'h08,8'h08,8'h08,8'h07},
        '{8'hf0,8'h88,8'h44,8'h44,8'h44,8'h80,8'h07,8'h08,8'h08,8'h08,8'h08,8'h07},
        '{8'h04,8'h04,8'h04,8'hc4,8'h34,8'h0c,8'h00,8'h0c,8'h03,8'h00,8'h00,8'h00},
        '{8'h18,8'ha4,8'h44,8'h44,8'ha4,8'h18,8'h07,8'h08,8'h08,8'h08,8'h08,8'h07},
        '{8'h78,8'h84,8'h84,8'h84,8'h44,8'hf8,8'h06,8'h08,8'h08,8'h08,8'h04,8'h03},
        '{8'h00,8'h00,8'h20,8'h70,8'h20,8'h00,8'h00,8'h00,8'h04,8'h0e,8'h04,8'h00},
        '{8'h00,8'h00,8'h60,8'h60,8'h00,8'h00,8'h00,8'h00,8'h12,8'h0e,8'h00,8'h00},
        '{8'h00,8'h80,8'h40,8'h20,8'h10,8'h08,8'h00,8'h00,8'h01,8'h02,8'h04,8'h08},
        '{8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01},
        '{8'h00,8'h08,8'h10,8'h20,8'h40,8'h80,8'h00,8'h08,8'h04,8'h02,8'h01,8'h00},
        '{8'h18,8'h04,8'h04,8'hc4,8'h24,8'h18,8'h00,8'h00,8'h00,8'h0d,8'h00,8'h00},
        '{8'hf0,8'h08,8'he4,8'h14,8'h14,8'hf8,8'h03,8'h04,8'h09,8'h0a,8'h0a,8'h0b},
        '{8'hf0,8'h88,8'h84,8'h84,8'h88,8'hf0,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h0f},
        '{8'hfc,8'h44,8'h44,8'h44,8'ha8,8'h10,8'h0f,8'h08,8'h08,8'h08,8'h04,8'h03},
        '{8'hf8,8'h04,8'h04,8'h04,8'h04,8'h18,8'h07,8'h08,8'h08,8'h08,8'h08,8'h06},
        '{8'hfc,8'h04,8'h04,8'h04,8'h08,8'hf0,8'h0f,8'h08,8'h08,8'h08,8'h04,8'h03},
        '{8'hfc,8'h44,8'h44,8'h44,8'h04,8'h04,8'h0f,8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'hfc,8'h44,8'h44,8'h44,8'h04,8'h04,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'hf8,8'h04,8'h04,8'h84,8'h84,8'h98,8'h07,8'h08,8'h08,8'h08,8'h04,8'h0f},
        '{8'hfc,8'h40,8'h40,8'h40,8'h40,8'hfc,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h0f},
        '{8'h00,8'h04,8'h04,8'hfc,8'h04,8'h04,8'h00,8'h08,8'h08,8'h0f,8'h08,8'h08},
        '{8'h00,8'h00,8'h00,8'h04,8'hfc,8'h04,8'h06,8'h08,8'h08,8'h08,8'h07,8'h00},
        '{8'hfc,8'h40,8'ha0,8'h10,8'h08,8'h04,8'h0f,8'h00,8'h00,8'h01,8'h02,8'h0c},
        '{8'hfc,8'h00,8'h00,8'h00,8'h00,8'h00,8'h0f,8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'hfc,8'h18,8'h60,8'h60,8'h18,8'hfc,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h0f},
        '{8'hfc,8'h30,8'h40,8'h80,8'h00,8'hfc,8'h0f,8'h00,8'h00,8'h00,8'h03,8'h0f},
        '{8'hf8,8'h04,8'h04,8'h04,8'h04,8'hf8,8'h07,8'h08,8'h08,8'h08,8'h08,8'h07},
        '{8'hfc,8'h84,8'h84,8'h84,8'h84,8'h78,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'hf8,8'h04,8'h04,8'h04,8'h04,8'hf8,8'h07,8'h09,8'h09,8'h0a,8'h1c,8'h27},
        '{8'hfc,8'h84,8'h84,8'h84,8'h84,8'h78,8'h0f,8'h00,8'h00,8'h01,8'h02,8'h0c},
        '{8'h38,8'h44,8'h44,8'h84,8'h84,8'h18,8'h06,8'h08,8'h08,8'h08,8'h08,8'h07},
        '{8'h04,8'h04,8'h04,8'hfc,8'h04,8'h04,8'h00,8'h00,8'h00,8'h0f,8'h00,8'h00},
        '{8'hfc,8'h00,8'h00,8'h00,8'h00,8'hfc,8'h07,8'h08,8'h08,8'h08,8'h08,8'h07},
        '{8'h3c,8'hc0,8'h00,8'h00,8'hc0,8'h3c,8'h00,8'h01,8'h0e,8'h0e,8'h01,8'h00},
        '{8'h00,8'hfc,8'h00,8'h00,8'h00,8'hfc,8'h00,8'h07,8'h08,8'h07,8'h08,8'h07},
        '{8'h0c,8'h30,8'hc0,8'hc0,8'h30,8'h0c,8'h0c,8'h03,8'h00,8'h00,8'h03,8'h0c},
        '{8'h00,8'h1c,8'h60,8'h80,8'h60,8'h1c,8'h00,8'h00,8'h00,8'h0f,8'h00,8'h00},
        '{8'h04,8'h04,8'h84,8'h64,8'h14,8'h0c,8'h0c,8'h0b,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h00,8'hfe,8'h02,8'h02,8'h02,8'h00,8'h00,8'h3f,8'h20,8'h20,8'h20},
        '{8'h06,8'h18,8'he0,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h03,8'h0c,8'h30},
        '{8'h00,8'h02,8'h02,8'h02,8'hfe,8'h00,8'h00,8'h20,8'h20,8'h20,8'h3f,8'h00},
        '{8'h08,8'h04,8'h02,8'h02,8'h04,8'h08,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20},
        '{8'h00,8'h00,8'h02,8'h04,8'h08,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h40,8'h20,8'h20,8'h20,8'h20,8'hc0,8'h06,8'h09,8'h09,8'h09,8'h09,8'h0f},
        '{8'hfc,8'h40,8'h20,8'h20,8'h20,8'hc0,8'h0f,8'h04,8'h08,8'h08,8'h08,8'h07},
        '{8'hc0,8'h20,8'h20,8'h20,8'h20,8'h40,8'h07,8'h08,8'h08,8'h08,8'h08,8'h04},
        '{8'hc0,8'h20,8'h20,8'h20,8'h40,8'hfc,8'h07,8'h08,8'h08,8'h08,8'h04,8'h0f},
        '{8'hc0,8'h20,8'h20,8'h20,8'h20,8'hc0,8'h07,8'h09,8'h09,8'h09,8'h09,8'h05},
        '{8'h40,8'h40,8'hf8,8'h44,8'h44,8'h08,8'h00,8'h00,8'h0f,8'h00,8'h00,8'h00},
        '{8'hc0,8'h20,8'h20,8'h20,8'hc0,8'h20,8'h19,8'h26,8'h2a,8'h2a,8'h29,8'h10},
        '{8'hfc,8'h40,8'h20,8'h20,8'h20,8'hc0,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h0f},
        '{8'h00,8'h00,8'h20,8'hec,8'h00,8'h00,8'h00,8'h08,8'h08,8'h0f,8'h08,8'h08},
        '{8'h00,8'h00,8'h00,8'h00,8'h20,8'hec,8'h00,8'h18,8'h20,8'h20,8'h20,8'h1f},
        '{8'hfc,8'h00,8'h80,8'h40,8'h20,8'h00,8'h0f,8'h01,8'h01,8'h02,8'h04,8'h08},
        '{8'h00,8'h00,8'h04,8'hfc,8'h00,8'h00,8'h00,8'h08,8'h08,8'h0f,8'h08,8'h08},
        '{8'h00,8'he0,8'h20,8'hc0,8'h20,8'hc0,8'h00,8'h0f,8'h00,8'h07,8'h00,8'h0f},
        '{8'he0,8'h40,8'h20,8'h20,8'h20,8'hc0,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h0f},
        '{8'hc0,8'h20,8'h20,8'h20,8'h20,8'hc0,8'h07,8'h08,8'h08,8'h08,8'h08,8'h07},
        '{8'he0,8'h40,8'h20,8'h20,8'h20,8'hc0,8'h3f,8'h04,8'h08,8'h08,8'h08,8'h07},
        '{8'hc0,8'h20,8'h20,8'h20,8'h40,8'he0,8'h07,8'h08,8'h08,8'h08,8'h04,8'h3f},
        '{8'he0,8'h40,8'h20,8'h20,8'h20,8'hc0,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h40,8'ha0,8'h20,8'h20,8'h20,8'h40,8'h04,8'h08,8'h09,8'h09,8'h0a,8'h04},
        '{8'h20,8'h20,8'hfc,8'h20,8'h20,8'h00,8'h00,8'h00,8'h07,8'h08,8'h08,8'h04},
        '{8'he0,8'h00,8'h00,8'h00,8'h00,8'he0,8'h07,8'h08,8'h08,8'h08,8'h04,8'h0f},
        '{8'h00,8'he0,8'h00,8'h00,8'h00,8'he0,8'h00,8'h00,8'h03,8'h0c,8'h03,8'h00},
        '{8'h00,8'he0,8'h00,8'h80,8'h00,8'he0,8'h00,8'h07,8'h08,8'h07,8'h08,8'h07},
        '{8'h60,8'h80,8'h00,8'h00,8'h80,8'h60,8'h0c,8'h02,8'h01,8'h01,8'h02,8'h0c},
        '{8'he0,8'h00,8'h00,8'h00,8'h00,8'he0,8'h13,8'h24,8'h24,8'h24,8'h22,8'h1f},
        '{8'h20,8'h20,8'h20,8'ha0,8'h60,8'h20,8'h08,8'h0c,8'h0b,8'h08,8'h08,8'h08},
        '{8'h00,8'h00,8'h80,8'h7c,8'h02,8'h02,8'h00,8'h00,8'h00,8'h1f,8'h20,8'h20},
        '{8'h00,8'h00,8'h00,8'hfe,8'h00,8'h00,8'h00,8'h00,8'h00,8'h3f,8'h00,8'h00},
        '{8'h00,8'h02,8'h02,8'h7c,8'h80,8'h00,8'h00,8'h20,8'h20,8'h1f,8'h00,8'h00},
        '{8'h0c,8'h02,8'h04,8'h08,8'h10,8'h0c,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'hfe,8'hfe,8'hfe,8'hfe,8'hfe,8'hfe,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f}
    };

endpackage

// File: rtl/ots_front.sv
`timescale 1ns / 1ps

module ots_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [7:0]        s_char_code,
    input  logic              q_full,
    output logic              q_push,
    output ots_pkg::ots_job_t q_job
);

    logic [ots_pkg::COL_W-1:0] col_reg, col_next;
    logic                      lower_reg, lower_next;

    logic       accept;
    logic       is_restart;
    logic       is_break;
    logic       bad_code;
    logic       bad;
    logic [7:0] offset;
    logic [ots_pkg::GLYPH_IDX_W-1:0] glyph;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign is_restart = (s_action == ots_pkg::ACTION_RESTART);
    assign is_break   = (s_char_code == ots_pkg::CHAR_LF) || (s_char_code == ots_pkg::CHAR_CR);

    always_comb begin
        bad_code = (s_char_code < ots_pkg::CHAR_FIRST) ||
                   (s_char_code > ots_pkg::CHAR_LAST_PRINT);
        offset   = s_char_code - ots_pkg::CHAR_FIRST;
        glyph    = bad_code ? '0 : offset[ots_pkg::GLYPH_IDX_W-1:0];
        bad      = bad_code;
        // codes past the configured glyph count fall back to space
        if (int'(glyph) >= ots_pkg::GLYPH_COUNT) begin
            glyph = '0;
            bad   = 1'b1;
        end
    end

    always_comb begin
        col_next   = col_reg;
        lower_next = lower_reg;
        q_push     = 1'b0;
        if (accept) begin
            priority if (is_restart) begin
                col_next   = '0;
                lower_next = 1'b0;
            end else if (is_break) begin
                col_next   = '0;
                lower_next = 1'b1;
            end else begin
                col_next = col_reg + ots_pkg::COL_W'(ots_pkg::COL_STEP);
                q_push   = 1'b1;
            end
        end
    end

    assign q_job.glyph = glyph;
    assign q_job.bad   = bad;
    assign q_job.col   = col_reg;
    assign q_job.lower = lower_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            lower_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            lower_reg <= lower_next;
        end
    end

endmodule

// File: rtl/ots_queue.sv
`timescale 1ns / 1ps

module ots_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ots_pkg::ots_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output ots_pkg::ots_job_t pop_job
);

    ots_pkg::ots_job_t entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/ots_back.sv
`timescale 1ns / 1ps

module ots_back #(
    parameter int GLYPH_BYTES = ots_pkg::GLYPH_BYTES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  ots_pkg::ots_job_t q_job,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_is_data,
    output logic              m_end_of_transfer,
    output logic              m_bad_char,
    output logic              m_last
);

    localparam int TOTAL  = ots_pkg::CMD_BYTES + GLYPH_BYTES;
    localparam int STEP_W = $clog2(TOTAL);
    localparam int SEL_W  = (STEP_W > ots_pkg::ROW_W) ? STEP_W : ots_pkg::ROW_W;

    localparam logic [STEP_W-1:0] STEP_COL_CMD   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_COL_START = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_COL_END   = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_PAGE_CMD  = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_PAGE_LO   = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_PAGE_HI   = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_FINAL     = STEP_W'(TOTAL - 1);

    logic                      busy_reg, busy_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [ots_pkg::COL_W-1:0] col_reg;
    logic                      lower_reg;
    logic                      bad_reg;
    ots_pkg::glyph_row_t       row_reg;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_out_byte_reg;
    logic       m_is_data_reg;
    logic       m_eot_reg;
    logic       m_bad_reg;
    logic       m_last_reg;

    logic             out_free;
    logic             advance;
    logic             at_final;
    logic             load;
    logic [SEL_W-1:0] data_idx;
    logic [7:0]       byte_sel;
    logic             data_sel;
    logic             eot_sel;
    logic [ots_pkg::COL_W-1:0] col_end;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = busy_reg && out_free;
    assign at_final = (step_reg == STEP_FINAL);
    // pick up the next glyph in the cycle the current one sends its last byte
    assign load     = !q_empty && (!busy_reg || (advance && at_final));
    assign q_pop    = load;

    assign col_end  = col_reg + ots_pkg::COL_W'(ots_pkg::COL_SPAN);
    assign data_idx = SEL_W'(step_reg) - SEL_W'(ots_pkg::CMD_BYTES);

    always_comb begin
        data_sel = 1'b0;
        eot_sel  = 1'b0;
        byte_sel = '0;
        unique case (step_reg)
            STEP_COL_CMD:   byte_sel = ots_pkg::CMD_COLUMN_ADDR;
            STEP_COL_START: byte_sel = {1'b0, col_reg};
            STEP_COL_END: begin
                byte_sel = {1'b0, col_end};
                eot_sel  = 1'b1;
            end
            STEP_PAGE_CMD:  byte_sel = ots_pkg::CMD_PAGE_ADDR;
            STEP_PAGE_LO:   byte_sel = {6'b0, lower_reg, 1'b0};
            STEP_PAGE_HI: begin
                byte_sel = {6'b0, lower_reg, 1'b1};
                eot_sel  = 1'b1;
            end
            default: begin
                data_sel = 1'b1;
                eot_sel  = at_final;
                if (int'(data_idx) < ots_pkg::ROM_STRIDE) begin
                    byte_sel = row_reg[data_idx[ots_pkg::ROW_W-1:0]];
                end
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        priority if (load) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (advance && at_final) begin
            busy_next = 1'b0;
        end else if (advance) begin
            step_next = step_reg + STEP_W'(1);
        end
        m_valid_next = advance || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            col_reg   <= q_job.col;
            lower_reg <= q_job.lower;
            bad_reg   <= q_job.bad;
            if (int'(q_job.glyph) < ots_pkg::ROM_GLYPHS) begin
                row_reg <= ots_pkg::GLYPH_ROM[q_job.glyph];
            end else begin
                row_reg <= '0;
            end
        end
        if (advance) begin
            m_out_byte_reg <= byte_sel;
            m_is_data_reg  <= data_sel;
            m_eot_reg      <= eot_sel;
            m_bad_reg      <= bad_reg;
            m_last_reg     <= at_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_byte        = m_out_byte_reg;
    assign m_is_data         = m_is_data_reg;
    assign m_end_of_transfer = m_eot_reg;
    assign m_bad_char        = m_bad_reg;
    assign m_last            = m_last_reg;

endmodule

// File: rtl/oled_text_glyph_streamer.sv
`timescale 1ns / 1ps

// Text-to-SPI byte streamer for a small OLED: each printable character becomes
// 6 + GLYPH_BYTES bytes (18 by default): a column-address command transfer, a
// page-address command transfer and one data transfer of glyph bytes, sent one
// per cycle from the output register while m_ready is high, with no gap between
// consecutive characters. A restart or a line break is taken from the input and
// produces nothing. The input side takes one item per cycle until the two-entry
// glyph queue is full; so once two characters wait behind the one being sent,
// s_ready drops and a character is taken only when the byte sequencer pops the
// queue. Reset is synchronous.
module oled_text_glyph_streamer #(
    parameter int GLYPH_BYTES = ots_pkg::GLYPH_BYTES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_data,
    output logic       m_end_of_transfer,
    output logic       m_bad_char,
    output logic       m_last
);

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    ots_pkg::ots_job_t push_job;
    ots_pkg::ots_job_t pop_job;

    ots_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_char_code (s_char_code),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    ots_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    ots_back #(
        .GLYPH_BYTES (GLYPH_BYTES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_empty           (q_empty),
        .q_job             (pop_job),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_is_data         (m_is_data),
        .m_end_of_transfer (m_end_of_transfer),
        .m_bad_char        (m_bad_char),
        .m_last            (m_last)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("glyph queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("glyph queue read while empty");

    a_restart_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ots_pkg::ACTION_RESTART)) |-> !q_push)
        else $error("restart request queued a glyph");

    a_last_closes_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_is_data && m_end_of_transfer))
        else $error("final byte of a character is not a closing data byte");

endmodule
